[hw/rtl/pfx_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfx_pkg
// shared constants and types of the postfix expression evaluator
// ----------------------------------------------------------------------------
package pfx_pkg;

	localparam int STACK_DEPTH = 16;
	localparam int VALUE_WIDTH = 32;
	localparam int CHAR_WIDTH  = 8;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W      = $clog2(STACK_DEPTH);

	localparam logic [CHAR_WIDTH-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_WIDTH-1:0] CH_NINE  = 8'h39;
	localparam logic [CHAR_WIDTH-1:0] CH_PLUS  = 8'h2b;
	localparam logic [CHAR_WIDTH-1:0] CH_MINUS = 8'h2d;
	localparam logic [CHAR_WIDTH-1:0] CH_STAR  = 8'h2a;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_UNDER = 2'd1,
		ST_OVER  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL
	} op_t;

	typedef logic [VALUE_WIDTH-1:0] value_t;

endpackage

[hw/rtl/pfx_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfx_if
// valid/ready channels for expression characters and evaluation results
// ----------------------------------------------------------------------------
interface pfx_char_if;
	logic                             valid;
	logic                             ready;
	logic [pfx_pkg::CHAR_WIDTH-1:0]   ch;
	logic                             last;

	modport source (output valid, output ch, output last, input ready);
	modport sink   (input valid, input ch, input last, output ready);
endinterface

interface pfx_result_if;
	logic                                    valid;
	logic                                    ready;
	logic signed [pfx_pkg::VALUE_WIDTH-1:0]  value;
	logic [1:0]                              status;

	modport source (output valid, output value, output status, input ready);
	modport sink   (input valid, input value, input status, output ready);
endinterface

[hw/rtl/pfx_stack_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfx_stack_ram
// operand stack storage, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module pfx_stack_ram (
	input  logic                        clk,
	input  logic                        we,
	input  logic [pfx_pkg::ADDR_W-1:0]  waddr,
	input  pfx_pkg::value_t             wdata,
	input  logic [pfx_pkg::ADDR_W-1:0]  raddr,
	output pfx_pkg::value_t             rdata
);

	pfx_pkg::value_t mem [pfx_pkg::STACK_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

[hw/rtl/pfx_alu.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfx_alu
// wrapping add, subtract and multiply of two stack operands
// ----------------------------------------------------------------------------
module pfx_alu (
	input  pfx_pkg::op_t    op,
	input  pfx_pkg::value_t left,
	input  pfx_pkg::value_t right,
	output pfx_pkg::value_t result
);

	always_comb begin
		case (op)
			pfx_pkg::OP_ADD: result = left + right;
			pfx_pkg::OP_SUB: result = left - right;
			pfx_pkg::OP_MUL: result = left * right;
			default:         result = left + right;
		endcase
	end

endmodule

[hw/rtl/postfix_expression_evaluator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// postfix_expression_evaluator
// evaluates a postfix expression given one character per item
// ----------------------------------------------------------------------------
// The block takes one character every clock cycle, with no gaps between items,
// as long as the result register is free or being emptied. Digits build a
// decimal number, any other character pushes it, and plus, minus and star
// replace the top two operands by their wrapped result. The operand stack lives
// in a synchronous RAM; the top entry is held in a register and the entry below
// it is read ahead from the RAM, so an operator finds both operands
// at once and the single RAM write port takes the one push of each item. The
// item marked last produces one result (value and status), which the output
// register takes as the item is accepted, and the block then starts afresh.
// A fault (too few operands, push onto a full stack) is sticky; the first one
// is reported and the value then reads zero. No clearing pass is needed.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator (
	input  logic                 clk,
	input  logic                 arst_n,
	pfx_char_if.sink             chars,
	pfx_result_if.source         results
);

	localparam int CW = pfx_pkg::CNT_W;
	localparam int AW = pfx_pkg::ADDR_W;

	logic [CW-1:0]     count_q;
	pfx_pkg::value_t   tos_q;
	pfx_pkg::value_t   acc_q;
	logic              in_num_q;
	pfx_pkg::status_t  fault_q;

	logic              res_valid_q;
	pfx_pkg::value_t   res_value_q;
	pfx_pkg::status_t  res_status_q;

	pfx_pkg::value_t   nos;
	pfx_pkg::value_t   alu_res;
	pfx_pkg::op_t      op;

	logic              accept;
	logic              is_digit;
	logic              is_op;
	logic              do_push;
	logic              num_pushed;
	pfx_pkg::value_t   alu_left;
	pfx_pkg::value_t   alu_right;
	pfx_pkg::value_t   push_val;
	pfx_pkg::value_t   acc_next;
	logic [CW-1:0]     c1;
	logic [CW-1:0]     c2;
	logic [CW-1:0]     c_next;
	pfx_pkg::value_t   t1;
	pfx_pkg::value_t   n1;
	pfx_pkg::value_t   t2;
	pfx_pkg::status_t  fault_n;
	pfx_pkg::status_t  fin_status;
	logic              we;
	logic [AW-1:0]     waddr;
	logic [AW-1:0]     raddr;

	assign accept        = chars.valid && chars.ready;
	assign chars.ready   = !res_valid_q || results.ready;
	assign results.valid  = res_valid_q;
	assign results.value  = res_value_q;
	assign results.status = res_status_q;

	always_comb begin
		is_digit = (chars.ch >= pfx_pkg::CH_ZERO) && (chars.ch <= pfx_pkg::CH_NINE);
		is_op    = 1'b1;
		op       = pfx_pkg::OP_ADD;
		case (chars.ch)
			pfx_pkg::CH_PLUS:  op = pfx_pkg::OP_ADD;
			pfx_pkg::CH_MINUS: op = pfx_pkg::OP_SUB;
			pfx_pkg::CH_STAR:  op = pfx_pkg::OP_MUL;
			default:           is_op = 1'b0;
		endcase
	end

	// operands of an operator, taken straight from the registers
	assign num_pushed = in_num_q && (count_q != CW'(pfx_pkg::STACK_DEPTH));
	assign alu_left   = num_pushed ? tos_q : nos;
	assign alu_right  = num_pushed ? acc_q : tos_q;

	pfx_alu u_alu (
		.op     (op),
		.left   (alu_left),
		.right  (alu_right),
		.result (alu_res)
	);

	always_comb begin
		acc_next = (acc_q << 3) + (acc_q << 1)
			+ pfx_pkg::VALUE_WIDTH'(chars.ch[3:0]);
		fault_n  = fault_q;

		// push of a pending number
		do_push  = is_digit ? chars.last : in_num_q;
		push_val = is_digit ? acc_next : acc_q;
		c1 = count_q;
		t1 = tos_q;
		n1 = nos;
		we = 1'b0;
		if (do_push) begin
			if (count_q == CW'(pfx_pkg::STACK_DEPTH)) begin
				if (fault_n == pfx_pkg::ST_OK) begin
					fault_n = pfx_pkg::ST_OVER;
				end
			end else begin
				c1 = count_q + CW'(1);
				t1 = push_val;
				n1 = tos_q;
				we = 1'b1;
			end
		end

		// operator: pop two, push one
		c2 = c1;
		t2 = t1;
		if (!is_digit && is_op) begin
			if (c1 < CW'(2)) begin
				if (fault_n == pfx_pkg::ST_OK) begin
					fault_n = pfx_pkg::ST_UNDER;
				end
			end else begin
				c2 = c1 - CW'(1);
				t2 = alu_res;
				we = 1'b1;
			end
		end
		we    = we && accept;
		waddr = AW'(c2 - CW'(1));

		if (fault_n != pfx_pkg::ST_OK) begin
			fin_status = fault_n;
		end else if (c2 == CW'(0)) begin
			fin_status = pfx_pkg::ST_UNDER;
		end else begin
			fin_status = pfx_pkg::ST_OK;
		end

		if (!accept) begin
			c_next = count_q;
		end else if (chars.last) begin
			c_next = CW'(0);
		end else begin
			c_next = c2;
		end
		raddr = AW'(c_next - CW'(2));
	end

	pfx_stack_ram u_stack (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (t2),
		.raddr (raddr),
		.rdata (nos)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			acc_q    <= '0;
			in_num_q <= 1'b0;
			fault_q  <= pfx_pkg::ST_OK;
		end else if (accept) begin
			count_q <= c_next;
			if (chars.last) begin
				acc_q    <= '0;
				in_num_q <= 1'b0;
				fault_q  <= pfx_pkg::ST_OK;
			end else begin
				acc_q    <= is_digit ? acc_next : '0;
				in_num_q <= is_digit;
				fault_q  <= fault_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tos_q <= t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept && chars.last) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && chars.last) begin
			res_status_q <= fin_status;
			res_value_q  <= (fin_status == pfx_pkg::ST_OK) ? t2 : '0;
		end
	end

endmodule

[sim/pfx_result_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfx_result_checker
// watches both channels, evaluates every accepted expression character on its
// own operand stack and compares each result item with the oldest prediction
// ----------------------------------------------------------------------------
module pfx_result_checker (
	input  logic         clk,
	input  logic         arst_n,
	pfx_char_if          chars,
	pfx_result_if        results,
	output int           mismatches,
	output int           outstanding
);
	import pfx_pkg::*;

	typedef struct {
		value_t  value;
		status_t status;
	} eval_result_t;

	value_t       operands [STACK_DEPTH];
	int unsigned  depth;
	value_t       number;
	bit           building;
	status_t      fault;
	eval_result_t expected_results [$];

	task automatic clear_eval();
		foreach (operands[i]) operands[i] = '0;
		depth    = 0;
		number   = '0;
		building = 1'b0;
		fault    = ST_OK;
	endtask

	task automatic push_operand(input value_t v);
		if (depth >= STACK_DEPTH) begin
			if (fault == ST_OK) fault = ST_OVER;
		end else begin
			operands[depth] = v;
			depth++;
		end
	endtask

	task automatic flush_number();
		if (building) begin
			push_operand(number);
			number   = '0;
			building = 1'b0;
		end
	endtask

	task automatic eval_char(input logic [CHAR_WIDTH-1:0] c, input logic is_last);
		value_t       lhs;
		value_t       rhs;
		eval_result_t res;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			number   = number * value_t'(10) + value_t'(c - CH_ZERO);
			building = 1'b1;
		end else begin
			flush_number();
			if (c == CH_PLUS || c == CH_MINUS || c == CH_STAR) begin
				if (depth < 2) begin
					if (fault == ST_OK) fault = ST_UNDER;
				end else begin
					rhs   = operands[depth-1];
					lhs   = operands[depth-2];
					depth = depth - 2;
					case (c)
						CH_PLUS: begin
							push_operand(lhs + rhs);
						end
						CH_MINUS: begin
							push_operand(lhs - rhs);
						end
						default: begin
							push_operand(lhs * rhs);
						end
					endcase
				end
			end
		end
		if (is_last) begin
			flush_number();
			res.value = '0;
			if (fault != ST_OK) begin
				res.status = fault;
			end else if (depth == 0) begin
				res.status = ST_UNDER;
			end else begin
				res.status = ST_OK;
				res.value  = operands[depth-1];
			end
			expected_results.push_back(res);
			clear_eval();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		eval_result_t exp_res;
		if (!arst_n) begin
			clear_eval();
			expected_results.delete();
			mismatches  = 0;
			outstanding = 0;
		end else begin
			if (results.valid && results.ready) begin
				if (expected_results.size() == 0) begin
					$error("result item with nothing expected: value %0d status %0d",
						$signed(results.value), results.status);
					mismatches++;
				end else begin
					exp_res = expected_results.pop_front();
					if (results.value !== exp_res.value) begin
						$error("value: expected %0d, got %0d",
							$signed(exp_res.value), $signed(results.value));
						mismatches++;
					end
					if (results.status !== 2'(exp_res.status)) begin
						$error("status: expected %0d, got %0d",
							exp_res.status, results.status);
						mismatches++;
					end
				end
			end
			if (chars.valid && chars.ready) eval_char(chars.ch, chars.last);
			outstanding = expected_results.size();
		end
	end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// feeds the postfix evaluator with directed and random expressions under
// changing sender and receiver idling, and reports the verdict of the checker
// ----------------------------------------------------------------------------
module tb_top;
	import pfx_pkg::*;

	localparam int HOLD_CYCLES = 400;
	localparam int CYCLE_LIMIT = 500000;
	localparam int PHASE_ITEMS = 470;

	logic clk;
	logic arst_n;
	int   mismatches;
	int   outstanding;
	int   cycle_count;
	int   items_sent;
	int   send_idle_pct;
	int   recv_idle_pct;
	bit   hold_req;
	bit   after_number;

	logic [CHAR_WIDTH-1:0] expr_q [$];

	pfx_char_if   chars_if ();
	pfx_result_if results_if ();

	postfix_expression_evaluator uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.chars   (chars_if),
		.results (results_if)
	);

	pfx_result_checker eval_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.chars       (chars_if),
		.results     (results_if),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb: failure");
		$finish;
	end

	// result side, with a single long hold-off during the last phase
	initial begin
		results_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				results_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			results_if.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	function automatic logic [CHAR_WIDTH-1:0] rand_sep();
		logic [CHAR_WIDTH-1:0] c;
		if ($urandom_range(9) < 7) return 8'h20;
		do
			c = 8'($urandom_range(255));
		while ((c >= CH_ZERO && c <= CH_NINE) || c == CH_PLUS || c == CH_MINUS
			|| c == CH_STAR);
		return c;
	endfunction

	task automatic emit_number();
		int unsigned n;
		if (after_number) expr_q.push_back(rand_sep());
		n = ($urandom_range(9) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 3);
		repeat (n) expr_q.push_back(CH_ZERO + 8'($urandom_range(9)));
		after_number = 1'b1;
	endtask

	task automatic emit_op();
		if (after_number && $urandom_range(1)) expr_q.push_back(rand_sep());
		case ($urandom_range(2))
			0: begin
				expr_q.push_back(CH_PLUS);
			end
			1: begin
				expr_q.push_back(CH_MINUS);
			end
			default: begin
				expr_q.push_back(CH_STAR);
			end
		endcase
		if ($urandom_range(3) == 0) expr_q.push_back(rand_sep());
		after_number = 1'b0;
	endtask

	task automatic build_expr();
		int unsigned kind;
		int unsigned k;
		int unsigned depth;
		int unsigned left;
		after_number = 1'b0;
		kind = $urandom_range(99);
		if (kind < 60) begin
			// well-formed expression
			k     = $urandom_range(1, 8);
			left  = k;
			depth = 0;
			while (left > 0 || depth > 1) begin
				if (left > 0 && (depth < 2 || $urandom_range(1))) begin
					emit_number();
					depth++;
					left--;
				end else begin
					emit_op();
					depth--;
				end
			end
		end else if (kind < 85) begin
			// near-full or overfull stack
			k = $urandom_range(12, 19);
			repeat (k) emit_number();
			repeat ($urandom_range(0, k - 1)) emit_op();
		end else if (kind < 93) begin
			// too few operands, or empty
			k = $urandom_range(0, 3);
			repeat (k) emit_number();
			repeat (k + $urandom_range(0, 1)) emit_op();
		end else begin
			repeat ($urandom_range(1, 12)) expr_q.push_back(8'($urandom_range(255)));
		end
		if ($urandom_range(3) == 0) expr_q.push_back(rand_sep());
	endtask

	task automatic send_item(input logic [CHAR_WIDTH-1:0] c, input logic is_last);
		while ($urandom_range(99) < send_idle_pct) begin
			chars_if.valid <= 1'b0;
			@(posedge clk);
		end
		chars_if.valid <= 1'b1;
		chars_if.ch    <= c;
		chars_if.last  <= is_last;
		@(posedge clk);
		while (!chars_if.ready) @(posedge clk);
		items_sent++;
	endtask

	task automatic send_expr();
		foreach (expr_q[i]) send_item(expr_q[i], i == expr_q.size() - 1);
		expr_q.delete();
	endtask

	task automatic send_str(input string s);
		for (int i = 0; i < s.len(); i++) expr_q.push_back(s[i]);
		send_expr();
	endtask

	task automatic wait_drained();
		chars_if.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	task automatic run_phase(input int send_pct, input int recv_pct, input bit with_hold);
		int start;
		bit paused;
		bit held;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		start  = items_sent;
		paused = 1'b0;
		held   = 1'b0;
		while (items_sent - start < PHASE_ITEMS) begin
			build_expr();
			send_expr();
			if (!paused && items_sent - start >= PHASE_ITEMS / 3) begin
				paused = 1'b1;
				wait_drained();
			end
			if (with_hold && !held && items_sent - start >= PHASE_ITEMS / 2) begin
				held     = 1'b1;
				hold_req = 1'b1;
			end
		end
		wait_drained();
	endtask

	initial begin
		arst_n         = 1'b0;
		hold_req       = 1'b0;
		items_sent     = 0;
		send_idle_pct  = 0;
		recv_idle_pct  = 0;
		chars_if.valid <= 1'b0;
		chars_if.ch    <= '0;
		chars_if.last  <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed expressions
		send_str("7 8+");
		send_str("0 9-");
		send_str("6 7*");
		send_str("+");
		send_str(" ");
		send_str("5");
		expr_q.push_back(8'h00);
		expr_q.push_back(CH_ZERO + 8'd2);
		expr_q.push_back(8'hff);
		expr_q.push_back(CH_ZERO + 8'd3);
		expr_q.push_back(CH_STAR);
		send_expr();
		wait_drained();

		run_phase(17, 86, 1'b0);
		run_phase(86, 17, 1'b0);
		run_phase(0, 0, 1'b1);

		repeat (16) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
